/* sv/mntu_pkg.sv */
// Package for the modular number theory unit.
// Holds the shared widths and the divider request and response types.
// No dependencies.
package mntu_pkg;
	localparam int W  = 32;
	localparam int DW = 2 * W;
	localparam int CW = $clog2(DW);
	localparam logic [W-1:0] MOD_RESET = W'(1000000007);

	typedef enum logic [1:0] {
		K_POW = 2'd0,
		K_INV = 2'd1,
		K_GCD = 2'd2,
		K_LCM = 2'd3
	} kind_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] dividend;
		logic [W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [DW-1:0] quotient;
		logic [W-1:0]  remainder;
	} div_rsp_t;
endpackage

/* sv/modular_number_theory_unit.sv */
// Modular power, modular inverse, gcd and lcm on one shared divider and multiplier.
// Each modular product or Euclid step costs one 64-step division plus its sequencing states;
// a 32-bit power needs at most 63 products.
// One transaction at a time: busy stays high until done pulses; the receiver cannot stall.
// Reset clears the sequencer and loads the modulus with 1000000007.
// Depends on mntu_pkg and mntu_div.
module modular_number_theory_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [mntu_pkg::W-1:0] operand_a,
	input  logic [mntu_pkg::W-1:0] operand_b,
	input  logic                  cfg_we,
	input  logic [mntu_pkg::W-1:0] cfg_wdata,
	output logic                  done,
	output logic [2*mntu_pkg::W-1:0] result,
	output logic                  undefined
);
	import mntu_pkg::*;

	typedef enum logic [3:0] {
		IDLE, PW_MUL, PW_DIV, PW_WAIT, IV_DIV, IV_WAIT, IV_MUL, IV_UPD, IV_FIX,
		GC_DIV, GC_WAIT, LC_DIV, LC_WAIT, LC_MUL
	} state_t;

	state_t          state_q;
	kind_t           kind_q;
	logic [W-1:0]    mod_q;
	logic [W-1:0]    x_q, y_q, e_q, a_q, b_q;
	logic            sq_q;
	logic signed [W+2:0] cu_q, cv_q;
	logic [DW-1:0]   prod_q;
	logic            done_q, undef_q;
	logic [DW-1:0]   res_q;

	div_req_t        div_req;
	div_rsp_t        div_rsp;

	logic [W-1:0]    mul_a;
	logic [W:0]      mul_b;
	logic [DW:0]     prod;
	logic [W+2:0]    cv_abs;
	logic signed [W+2:0] term, cv_next, fix1, fix2, m_ext;

	mntu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cv_abs = cv_q[W+2] ? -cv_q : cv_q;
	assign m_ext  = $signed({3'b000, mod_q});

	// The single multiplier, shared by power, inverse and lcm.
	always_comb begin
		mul_a = x_q;
		mul_b = {1'b0, y_q};
		case (state_q)
			PW_MUL: begin
				mul_a = sq_q ? y_q : x_q;
				mul_b = {1'b0, y_q};
			end
			IV_MUL: begin
				mul_a = e_q;
				mul_b = cv_abs[W:0];
			end
			LC_MUL: begin
				mul_a = e_q;
				mul_b = {1'b0, b_q};
			end
			default: begin
				mul_a = x_q;
				mul_b = {1'b0, y_q};
			end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {{W{1'b0}}, x_q};
		div_req.divisor  = y_q;
		case (state_q)
			PW_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = mod_q;
			end
			IV_DIV, GC_DIV: begin
				div_req.start = (y_q != '0);
			end
			LC_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {{W{1'b0}}, a_q};
				div_req.divisor  = x_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// Coefficient update and the final reduction into 0..m-1.
	assign term    = cv_q[W+2] ? -$signed(prod_q[W+2:0]) : $signed(prod_q[W+2:0]);
	assign cv_next = cu_q - term;
	assign fix1    = cu_q[W+2] ? cu_q + m_ext : cu_q;
	assign fix2    = (fix1 >= m_ext) ? fix1 - m_ext : fix1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			kind_q  <= K_POW;
			mod_q   <= MOD_RESET;
			x_q     <= '0;
			y_q     <= '0;
			e_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			sq_q    <= 1'b0;
			cu_q    <= '0;
			cv_q    <= '0;
			prod_q  <= '0;
			done_q  <= 1'b0;
			undef_q <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			case (state_q)
				IDLE: begin
					if (start) begin
						kind_q  <= kind_t'(kind);
						a_q     <= operand_a;
						b_q     <= operand_b;
						undef_q <= 1'b0;
						case (kind_t'(kind))
							K_POW: begin
								x_q  <= W'(1);
								y_q  <= operand_a;
								e_q  <= operand_b;
								sq_q <= ~operand_b[0];
								if (operand_b == '0) begin
									res_q   <= DW'(1);
									done_q  <= 1'b1;
								end else if (mod_q == '0) begin
									res_q   <= '0;
									done_q  <= 1'b1;
								end else begin
									state_q <= PW_MUL;
								end
							end
							K_INV: begin
								x_q  <= operand_a;
								y_q  <= mod_q;
								cu_q <= (W+3)'(1);
								cv_q <= '0;
								if (mod_q == '0) begin
									res_q   <= '0;
									done_q  <= 1'b1;
								end else begin
									state_q <= IV_DIV;
								end
							end
							default: begin
								x_q     <= operand_a;
								y_q     <= operand_b;
								state_q <= GC_DIV;
							end
						endcase
					end
				end
				PW_MUL: begin
					prod_q  <= prod[DW-1:0];
					state_q <= PW_DIV;
				end
				PW_DIV: begin
					state_q <= PW_WAIT;
				end
				PW_WAIT: begin
					if (div_rsp.done) begin
						if (!sq_q) begin
							x_q <= div_rsp.remainder;
							if (e_q[W-1:1] == '0) begin
								res_q   <= {{W{1'b0}}, div_rsp.remainder};
								done_q  <= 1'b1;
								state_q <= IDLE;
							end else begin
								sq_q    <= 1'b1;
								state_q <= PW_MUL;
							end
						end else begin
							y_q     <= div_rsp.remainder;
							e_q     <= e_q >> 1;
							sq_q    <= ~e_q[1];
							state_q <= PW_MUL;
						end
					end
				end
				IV_DIV: begin
					state_q <= (y_q == '0) ? IV_FIX : IV_WAIT;
				end
				IV_WAIT: begin
					if (div_rsp.done) begin
						e_q     <= div_rsp.quotient[W-1:0];
						x_q     <= y_q;
						y_q     <= div_rsp.remainder;
						state_q <= IV_MUL;
					end
				end
				IV_MUL: begin
					prod_q  <= prod[DW-1:0];
					state_q <= IV_UPD;
				end
				IV_UPD: begin
					cu_q    <= cv_q;
					cv_q    <= cv_next;
					state_q <= IV_DIV;
				end
				IV_FIX: begin
					res_q   <= {{W{1'b0}}, fix2[W-1:0]};
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				GC_DIV: begin
					if (y_q != '0) begin
						state_q <= GC_WAIT;
					end else if (kind_q == K_GCD) begin
						res_q   <= {{W{1'b0}}, x_q};
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else if (x_q == '0) begin
						// Both operands zero: the lcm has no value.
						res_q   <= '0;
						undef_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else begin
						state_q <= LC_DIV;
					end
				end
				GC_WAIT: begin
					if (div_rsp.done) begin
						x_q     <= y_q;
						y_q     <= div_rsp.remainder;
						state_q <= GC_DIV;
					end
				end
				LC_DIV: begin
					state_q <= LC_WAIT;
				end
				LC_WAIT: begin
					if (div_rsp.done) begin
						e_q     <= div_rsp.quotient[W-1:0];
						state_q <= LC_MUL;
					end
				end
				LC_MUL: begin
					res_q   <= prod[DW-1:0];
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != IDLE);
	assign done      = done_q;
	assign result    = res_q;
	assign undefined = undef_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still running");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (!div_rsp.busy && div_req.divisor != '0))
		else $error("divider started while busy or with a zero divisor");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && undefined) |-> (result == '0))
		else $error("undefined lcm with a nonzero result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind_t'(kind) == K_GCD) |=> busy)
		else $error("gcd transaction did not enter the sequencer");
endmodule

/* sv/mntu_div.sv */
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor.
// One quotient bit per cycle; depends on mntu_pkg.
module mntu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mntu_pkg::div_req_t req,
	output mntu_pkg::div_rsp_t rsp
);
	import mntu_pkg::*;

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  d_q;
	logic [W:0]    sh;
	logic [W:0]    diff;
	logic          ge;

	assign sh   = {rem_q, dvd_q[DW-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				dvd_q <= req.dividend;
				rem_q <= '0;
				d_q   <= req.divisor;
			end else if (run_q) begin
				// The quotient bits shift in where the dividend bits leave.
				dvd_q <= {dvd_q[DW-2:0], ge};
				rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = run_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;
endmodule
